/* rtl/core/ppir_pkg.sv */
// Shared types and constants of the progressive pixel interleave reorder unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ppir_pkg;

   // Field widths fixed by the item and register formats
   localparam int DIM_W   = 9;   // width and height registers
   localparam int COORD_W = 9;   // internal scan coordinates
   localparam int SUM_W   = 10;  // coordinate plus step
   localparam int LVL_W   = 3;   // interleave level
   localparam int PIX_W   = 8;
   localparam int OUT_W   = 8;   // reported coordinates
   localparam int ACT_W   = 2;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] CSR_IMG_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMG_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_STEP_LOG2  = 2'd2;

   // Request actions; the fourth code is unused and ignored
   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_SETTLE,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_ADV,
      ST_EMIT,
      ST_EMIT_ERR
   } state_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [LVL_W-1:0] step_log2;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic start;
      logic write;
      logic addr_calc;
      logic ram_rd;
      logic adv_step;
      logic out_load;
      logic out_err;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic read_bad;
      logic adv_finish;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/ppir_req_if.sv */
// Request channel: valid/ready handshake carrying action and pixel byte.
// Depends on ppir_pkg.
interface ppir_req_if;
   import ppir_pkg::*;

   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output action, output pixel_in, input ready);
   modport sink   (input valid, input action, input pixel_in, output ready);

endinterface

/* rtl/core/ppir_rsp_if.sv */
// Result channel: valid/ready handshake carrying pixel, coordinates and flags.
// Depends on ppir_pkg.
interface ppir_rsp_if;
   import ppir_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic [OUT_W-1:0] src_row;
   logic [OUT_W-1:0] src_col;
   logic             last_of_image;
   logic             order_error;

   modport source (output valid, output pixel_out, output src_row, output src_col,
                   output last_of_image, output order_error, input ready);
   modport sink   (input valid, input pixel_out, input src_row, input src_col,
                   input last_of_image, input order_error, output ready);

endinterface

/* rtl/core/progressive_pixel_interleave_reorder_unit.sv */
// Top level of the progressive pixel interleave reorder unit: register port,
// controller and datapath. Depends on ppir_pkg, ppir_req_if, ppir_rsp_if,
// ppir_ctrl and ppir_datapath.

// Loads a frame of byte pixels in raster order (action write) and hands them
// back one per read request in progressive interleaved order: first every
// pixel on multiples of the coarsest step 2^k, then for each halved step the
// pixels new at that level, each pass in raster order. A read before the frame
// is full or after the last pixel returns a result with order_error set. Frame
// start latches width, height and step (clamped to the parameter limits). The
// store needs no clearing pass after reset. Writes and unused codes finish in
// idle; a frame start passes the settle state, an error read the error emit
// state, and a good read address calculation, the store read, the advance unit
// stepping one scan position per cycle to the next pixel (normally 1 or 2
// positions; more where a refinement level leaves whole rows empty or a level
// change falls on the way) and the emit state. The result sits in an output
// register, so the next request is taken while it waits for the sink.
module progressive_pixel_interleave_reorder_unit #(
   parameter int MAX_WIDTH     = 256,
   parameter int MAX_HEIGHT    = 256,
   parameter int MAX_STEP_LOG2 = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   ppir_req_if.sink                    req_chan,
   ppir_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ppir_pkg::CSR_AW-1:0] paddr,
   input  logic [ppir_pkg::CSR_DW-1:0] pwdata,
   output logic [ppir_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import ppir_pkg::*;

   logic [DIM_W-1:0] img_width_ff;
   logic [DIM_W-1:0] img_height_ff;
   logic [LVL_W-1:0] step_log2_ff;
   logic             csr_wr;
   logic [1:0]       csr_idx;
   cfg_type          cfg;
   cmd_type          cmd;
   status_type       status;

   // Register port: zero-wait writes on the access phase
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= DIM_W'(256);
         img_height_ff <= DIM_W'(256);
         step_log2_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IMG_WIDTH:  img_width_ff  <= pwdata[DIM_W-1:0];
            CSR_IMG_HEIGHT: img_height_ff <= pwdata[DIM_W-1:0];
            CSR_STEP_LOG2:  step_log2_ff  <= pwdata[LVL_W-1:0];
            default: begin
               step_log2_ff <= step_log2_ff;
            end
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_idx)
         CSR_IMG_WIDTH:  prdata = CSR_DW'(img_width_ff);
         CSR_IMG_HEIGHT: prdata = CSR_DW'(img_height_ff);
         CSR_STEP_LOG2:  prdata = CSR_DW'(step_log2_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.width     = img_width_ff;
   assign cfg.height    = img_height_ff;
   assign cfg.step_log2 = step_log2_ff;

   ppir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   ppir_datapath #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .MAX_STEP_LOG2 (MAX_STEP_LOG2)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .pixel_in      (req_chan.pixel_in),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .pixel_out     (rsp_chan.pixel_out),
      .src_row       (rsp_chan.src_row),
      .src_col       (rsp_chan.src_col),
      .last_of_image (rsp_chan.last_of_image),
      .order_error   (rsp_chan.order_error)
   );

   // At most one datapath command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.write, cmd.addr_calc, cmd.ram_rd, cmd.adv_step,
                cmd.out_load, cmd.out_err}))
      else $error("more than one datapath command at once");

   // A result is only loaded when the output register can take it
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.out_err) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten before transfer");

   // A frame start holds off the next request through the settle state
   a_start_settle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action == ACT_START)
      |=> !req_chan.ready)
      else $error("request taken directly after frame start");

   // Error results carry no pixel, coordinates or last flag
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.order_error) |->
      (rsp_chan.pixel_out == '0 && rsp_chan.src_row == '0 &&
       rsp_chan.src_col == '0 && !rsp_chan.last_of_image))
      else $error("error result with payload");

endmodule

/* rtl/core/ppir_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read, held between reads
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/ppir_ctrl.sv */
// Controller of the reorder unit: sequences load, frame start and interleaved reads.
// Depends on ppir_pkg; drives the datapath through cmd_type, reads status_type.
module ppir_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [ppir_pkg::ACT_W-1:0] req_action,
   output logic                      req_ready,
   input  ppir_pkg::status_type      status,
   output ppir_pkg::cmd_type         cmd
);
   import ppir_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register; settle after reset and after each frame start so the frame total is fresh
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETTLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_SETTLE: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_action)
                  ACT_WRITE: begin
                     cmd.write = 1'b1;
                  end
                  ACT_START: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SETTLE;
                  end
                  ACT_READ: begin
                     if (status.read_bad) begin
                        state_in = ST_EMIT_ERR;
                     end else begin
                        state_in = ST_ADDR;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.ram_rd = 1'b1;
            state_in   = ST_ADV;
         end
         ST_ADV: begin
            cmd.adv_step = 1'b1;
            if (status.adv_finish) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_ERR: begin
            if (status.out_free) begin
               cmd.out_err = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SETTLE;
         end
      endcase
   end

endmodule

/* rtl/core/ppir_datapath.sv */
// Datapath of the reorder unit: frame store, load counter, scan position and
// level, one-step advance unit, address multiplier and result register.
// Depends on ppir_pkg and ppir_ram.
module ppir_datapath #(
   parameter int MAX_WIDTH     = 256,
   parameter int MAX_HEIGHT    = 256,
   parameter int MAX_STEP_LOG2 = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ppir_pkg::cfg_type           cfg,
   input  logic [ppir_pkg::PIX_W-1:0]  pixel_in,
   input  ppir_pkg::cmd_type           cmd,
   output ppir_pkg::status_type        status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ppir_pkg::PIX_W-1:0]  pixel_out,
   output logic [ppir_pkg::OUT_W-1:0]  src_row,
   output logic [ppir_pkg::OUT_W-1:0]  src_col,
   output logic                        last_of_image,
   output logic                        order_error
);
   import ppir_pkg::*;

   // Largest dimensions the registers can reach under the parameter caps
   localparam int DIM_MAX   = (1 << DIM_W) - 1;
   localparam int W_CAP     = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
   localparam int H_CAP     = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
   localparam int W_RST     = (W_CAP < 256) ? W_CAP : 256;
   localparam int H_RST     = (H_CAP < 256) ? H_CAP : 256;
   localparam int CAP_TOTAL = W_CAP * H_CAP;
   localparam int CNT_W     = $clog2(CAP_TOTAL + 1);
   localparam int AW        = (CAP_TOTAL > 1) ? $clog2(CAP_TOTAL) : 1;
   localparam int PROD_W    = 2 * DIM_W;
   localparam int ADDR_SW   = 2 * DIM_W + 1;

   localparam logic [DIM_W-1:0] W_CAP_V = DIM_W'(W_CAP);
   localparam logic [DIM_W-1:0] H_CAP_V = DIM_W'(H_CAP);
   localparam logic [LVL_W-1:0] K_CAP_V = LVL_W'(MAX_STEP_LOG2);

   logic [DIM_W-1:0]   frame_w_ff;
   logic [DIM_W-1:0]   frame_h_ff;
   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   load_cnt_ff;
   logic [LVL_W-1:0]   level_ff;
   logic               coarse_ff;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic               done_ff;
   logic [AW-1:0]      addr_ff;
   logic [OUT_W-1:0]   pend_row_ff;
   logic [OUT_W-1:0]   pend_col_ff;
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   pixel_out_ff;
   logic [OUT_W-1:0]   src_row_ff;
   logic [OUT_W-1:0]   src_col_ff;
   logic               last_ff;
   logic               err_ff;

   logic [DIM_W-1:0]   w_clamp;
   logic [DIM_W-1:0]   h_clamp;
   logic [LVL_W-1:0]   k_clamp;
   logic [PROD_W-1:0]  prod;
   logic [ADDR_SW-1:0] addr_sum;
   logic               load_open;
   logic               ram_we;
   logic [PIX_W-1:0]   ram_rdata;

   logic [SUM_W-1:0]   step;
   logic [SUM_W-1:0]   col_sum;
   logic [SUM_W-1:0]   row_sum;
   logic [COORD_W-1:0] mask;
   logic [COORD_W-1:0] row_in;
   logic [COORD_W-1:0] col_in;
   logic [LVL_W-1:0]   level_in;
   logic               coarse_in;
   logic               done_in;
   logic               adv_finish;

   // Clamp the registers as the frame is started
   always_comb begin
      priority if (cfg.width == '0) begin
         w_clamp = DIM_W'(1);
      end else if (cfg.width > W_CAP_V) begin
         w_clamp = W_CAP_V;
      end else begin
         w_clamp = cfg.width;
      end
      priority if (cfg.height == '0) begin
         h_clamp = DIM_W'(1);
      end else if (cfg.height > H_CAP_V) begin
         h_clamp = H_CAP_V;
      end else begin
         h_clamp = cfg.height;
      end
      k_clamp = (cfg.step_log2 > K_CAP_V) ? K_CAP_V : cfg.step_log2;
   end

   // Frame size in pixels, registered off the latched dimensions
   assign prod = PROD_W'(frame_w_ff) * PROD_W'(frame_h_ff);

   always_ff @(posedge clock) begin
      total_ff <= CNT_W'(prod);
   end

   // Store loads in raster order until the frame is full
   assign load_open = (load_cnt_ff < total_ff);
   assign ram_we    = cmd.write && load_open;

   // Raster address of the current scan position
   assign addr_sum = ADDR_SW'(row_ff) * ADDR_SW'(frame_w_ff) + ADDR_SW'(col_ff);

   always_ff @(posedge clock) begin
      if (cmd.addr_calc) begin
         addr_ff     <= addr_sum[AW-1:0];
         pend_row_ff <= row_ff[OUT_W-1:0];
         pend_col_ff <= col_ff[OUT_W-1:0];
      end
   end

   ppir_ram #(
      .WIDTH (PIX_W),
      .DEPTH (CAP_TOTAL)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (load_cnt_ff[AW-1:0]),
      .wdata (pixel_in),
      .re    (cmd.ram_rd),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // One position of the interleaved scan per step
   always_comb begin
      step       = SUM_W'(1) << level_ff;
      col_sum    = SUM_W'(col_ff) + step;
      row_sum    = SUM_W'(row_ff) + step;
      mask       = COORD_W'((SUM_W'(2) << level_ff) - SUM_W'(1));
      row_in     = row_ff;
      col_in     = col_sum[COORD_W-1:0];
      level_in   = level_ff;
      coarse_in  = coarse_ff;
      done_in    = done_ff;
      adv_finish = 1'b0;
      if (col_sum >= SUM_W'(frame_w_ff)) begin
         col_in = '0;
         if (row_sum >= SUM_W'(frame_h_ff)) begin
            row_in = '0;
            if (level_ff == '0) begin
               done_in    = 1'b1;
               adv_finish = 1'b1;
            end else begin
               // the origin never belongs to a refinement pass: keep going
               level_in  = level_ff - LVL_W'(1);
               coarse_in = 1'b0;
            end
         end else begin
            row_in     = row_sum[COORD_W-1:0];
            adv_finish = coarse_ff || ((row_in & mask) != '0) || ((col_in & mask) != '0);
         end
      end else begin
         adv_finish = coarse_ff || ((row_in & mask) != '0) || ((col_in & mask) != '0);
      end
   end

   // Frame and scan state
   always_ff @(posedge clock) begin
      priority if (reset) begin
         frame_w_ff  <= DIM_W'(W_RST);
         frame_h_ff  <= DIM_W'(H_RST);
         load_cnt_ff <= '0;
         level_ff    <= '0;
         coarse_ff   <= 1'b1;
         row_ff      <= '0;
         col_ff      <= '0;
         done_ff     <= 1'b0;
      end else if (cmd.start) begin
         frame_w_ff  <= w_clamp;
         frame_h_ff  <= h_clamp;
         load_cnt_ff <= '0;
         level_ff    <= k_clamp;
         coarse_ff   <= 1'b1;
         row_ff      <= '0;
         col_ff      <= '0;
         done_ff     <= 1'b0;
      end else if (cmd.adv_step) begin
         level_ff  <= level_in;
         coarse_ff <= coarse_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         done_ff   <= done_in;
      end else if (ram_we) begin
         load_cnt_ff <= load_cnt_ff + CNT_W'(1);
      end
   end

   // Result register: set on load, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.out_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pixel_out_ff <= ram_rdata;
         src_row_ff   <= pend_row_ff;
         src_col_ff   <= pend_col_ff;
         last_ff      <= done_ff;
         err_ff       <= 1'b0;
      end else if (cmd.out_err) begin
         pixel_out_ff <= '0;
         src_row_ff   <= '0;
         src_col_ff   <= '0;
         last_ff      <= 1'b0;
         err_ff       <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign pixel_out     = pixel_out_ff;
   assign src_row       = src_row_ff;
   assign src_col       = src_col_ff;
   assign last_of_image = last_ff;
   assign order_error   = err_ff;

   assign status.read_bad   = done_ff || load_open;
   assign status.adv_finish = adv_finish;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of progressive_pixel_interleave_reorder_unit: loads frames,
// reads them back in interleaved order and checks every result against a local order model.
// Depends on ppir_pkg, ppir_req_if, ppir_rsp_if and the unit's RTL.
module tb;
   import ppir_pkg::*;

   localparam int FRAME_MAX_W   = 256;
   localparam int FRAME_MAX_H   = 256;
   localparam int STEP_MAX_LOG2 = 6;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 40;
   localparam int READ_CAP      = 40;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [ACT_W-1:0] act;
      logic [PIX_W-1:0] pix;
   } req_item_type;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
      logic             last;
      logic             err;
   } pixel_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   ppir_req_if req_bus ();
   ppir_rsp_if rsp_bus ();

   progressive_pixel_interleave_reorder_unit #(
      .MAX_WIDTH     (FRAME_MAX_W),
      .MAX_HEIGHT    (FRAME_MAX_H),
      .MAX_STEP_LOG2 (STEP_MAX_LOG2)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Stimulus and expectation stores
   req_item_type     pending_requests [$];
   pixel_result_type expected_pixels [$];
   req_item_type     next_req;
   pixel_result_type got_pixel;
   pixel_result_type want_pixel;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               fail_count = 0;
   int               cycle_count = 0;
   int               phase_items;

   // Order model state: programmed registers, latched frame and scan position
   logic [PIX_W-1:0] pixel_store [0:FRAME_MAX_W*FRAME_MAX_H-1];
   logic [DIM_W-1:0] reg_width;
   logic [DIM_W-1:0] reg_height;
   logic [LVL_W-1:0] reg_step_log2;
   int               frame_w;
   int               frame_h;
   int               frame_k;
   int               load_count;
   int               level_shift;
   bit               coarse_pass;
   int               scan_row;
   int               scan_col;
   bit               order_done;

   function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      if (v == 0)
         return 1;
      if (int'(v) > hi)
         return hi;
      return int'(v);
   endfunction

   function automatic void latch_frame();
      frame_w     = clamp_dim(reg_width, FRAME_MAX_W);
      frame_h     = clamp_dim(reg_height, FRAME_MAX_H);
      frame_k     = (int'(reg_step_log2) > STEP_MAX_LOG2) ? STEP_MAX_LOG2 : int'(reg_step_log2);
      load_count  = 0;
      level_shift = frame_k;
      coarse_pass = 1'b1;
      scan_row    = 0;
      scan_col    = 0;
      order_done  = 1'b0;
   endfunction

   // Move to the next position of the interleaved order, or mark the order finished
   function automatic void advance_scan();
      int s;
      int m;
      while (1'b1) begin
         s = 1 << level_shift;
         scan_col += s;
         if (scan_col >= frame_w) begin
            scan_col = 0;
            scan_row += s;
            if (scan_row >= frame_h) begin
               if (level_shift == 0) begin
                  order_done = 1'b1;
                  scan_row   = 0;
                  return;
               end
               level_shift--;
               coarse_pass = 1'b0;
               scan_row    = 0;
               continue;
            end
         end
         if (coarse_pass)
            return;
         m = (2 << level_shift) - 1;
         if ((scan_row & m) != 0 || (scan_col & m) != 0)
            return;
      end
   endfunction

   // Update the model for one accepted request and queue the result it causes
   function automatic void apply_request(input logic [ACT_W-1:0] act, input logic [PIX_W-1:0] pix);
      int               total;
      pixel_result_type res;
      total = frame_w * frame_h;
      case (act)
         ACT_WRITE: begin
            if (load_count < total) begin
               pixel_store[load_count] = pix;
               load_count++;
            end
         end
         ACT_START: latch_frame();
         ACT_READ: begin
            if (order_done || load_count < total) begin
               res.pixel = '0;
               res.row   = '0;
               res.col   = '0;
               res.last  = 1'b0;
               res.err   = 1'b1;
            end else begin
               res.pixel = pixel_store[scan_row * frame_w + scan_col];
               res.row   = OUT_W'(scan_row);
               res.col   = OUT_W'(scan_col);
               res.err   = 1'b0;
               advance_scan();
               res.last  = order_done;
            end
            expected_pixels.push_back(res);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // Request driver: predict on each transfer, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            apply_request(req_bus.action, req_bus.pixel_in);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.action   <= next_req.act;
               req_bus.pixel_in <= next_req.pix;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want_pixel = expected_pixels.pop_front();
               got_pixel.pixel = rsp_bus.pixel_out;
               got_pixel.row   = rsp_bus.src_row;
               got_pixel.col   = rsp_bus.src_col;
               got_pixel.last  = rsp_bus.last_of_image;
               got_pixel.err   = rsp_bus.order_error;
               if (got_pixel.pixel !== want_pixel.pixel)
                  report_mismatch($sformatf("pixel_out %h, want %h",
                                            got_pixel.pixel, want_pixel.pixel));
               if (got_pixel.row !== want_pixel.row)
                  report_mismatch($sformatf("src_row %0d, want %0d",
                                            got_pixel.row, want_pixel.row));
               if (got_pixel.col !== want_pixel.col)
                  report_mismatch($sformatf("src_col %0d, want %0d",
                                            got_pixel.col, want_pixel.col));
               if (got_pixel.last !== want_pixel.last)
                  report_mismatch($sformatf("last_of_image %b, want %b",
                                            got_pixel.last, want_pixel.last));
               if (got_pixel.err !== want_pixel.err)
                  report_mismatch($sformatf("order_error %b, want %b",
                                            got_pixel.err, want_pixel.err));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Guard against a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct  = (mode == IDLE_SEND) ? 51 : (mode == IDLE_BOTH) ? 34 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 51 : (mode == IDLE_BOTH) ? 34 : 0;
   endtask

   task automatic queue_item(input logic [ACT_W-1:0] act, input logic [PIX_W-1:0] pix);
      req_item_type it;
      it.act = act;
      it.pix = pix;
      pending_requests.push_back(it);
      phase_items++;
   endtask

   // Hold until every request has transferred and every result has come back
   task automatic drain_all();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_IMG_WIDTH:  reg_width     = value[DIM_W-1:0];
         CSR_IMG_HEIGHT: reg_height    = value[DIM_W-1:0];
         CSR_STEP_LOG2:  reg_step_log2 = value[LVL_W-1:0];
         default: ;
      endcase
   endtask

   // Occasionally slip in an unused code or a stray read
   task automatic queue_noise();
      case ($urandom_range(39))
         0: queue_item(ACT_UNUSED, PIX_W'($urandom_range(255)));
         1: queue_item(ACT_READ, PIX_W'($urandom_range(255)));
         default: ;
      endcase
   endtask

   // One frame: start, load, read back; some frames restart part way or run past the end,
   // and some frames, and all large ones, are read back only over their first part
   task automatic queue_frame(input int total, input bit pause_mid);
      int n;
      int cut;
      queue_item(ACT_START, PIX_W'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(total)) queue_item(ACT_WRITE, PIX_W'($urandom_range(255)));
         queue_item(ACT_START, PIX_W'($urandom_range(255)));
      end
      for (n = 0; n < total; n++) begin
         queue_noise();
         queue_item(ACT_WRITE, PIX_W'($urandom_range(255)));
      end
      repeat ($urandom_range(2)) queue_item(ACT_WRITE, PIX_W'($urandom_range(255)));
      if (pause_mid)
         drain_all();
      cut = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
      if (cut > READ_CAP)
         cut = READ_CAP;
      for (n = 0; n < cut; n++) begin
         queue_noise();
         queue_item(ACT_READ, PIX_W'($urandom_range(255)));
      end
      if (cut == total)
         repeat ($urandom_range(2)) queue_item(ACT_READ, PIX_W'($urandom_range(255)));
   endtask

   task automatic run_phase(input logic [CSR_DW-1:0] w_raw, input logic [CSR_DW-1:0] h_raw,
                            input logic [CSR_DW-1:0] k_raw, input idle_mode_type mode,
                            input int budget, input bit pause_mid);
      int total;
      bit hold_once;
      drain_all();
      write_csr(CSR_IMG_WIDTH, w_raw);
      write_csr(CSR_IMG_HEIGHT, h_raw);
      write_csr(CSR_STEP_LOG2, k_raw);
      set_idle(mode);
      total = clamp_dim(w_raw[DIM_W-1:0], FRAME_MAX_W) * clamp_dim(h_raw[DIM_W-1:0], FRAME_MAX_H);
      hold_once = pause_mid;
      phase_items = 0;
      do begin
         queue_frame(total, hold_once);
         hold_once = 1'b0;
      end while (phase_items < budget);
   endtask

   initial begin
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_bus.valid    = 1'b0;
      req_bus.action   = ACT_WRITE;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      reg_width        = DIM_W'(FRAME_MAX_W);
      reg_height       = DIM_W'(FRAME_MAX_H);
      reg_step_log2    = '0;
      latch_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset frame: reads before any load, unused code, restart
      set_idle(IDLE_NONE);
      queue_item(ACT_READ, 8'h00);
      queue_item(ACT_UNUSED, 8'hFF);
      queue_item(ACT_WRITE, 8'h00);
      queue_item(ACT_WRITE, 8'hFF);
      queue_item(ACT_START, 8'hAA);
      queue_item(ACT_READ, 8'h55);
      drain_all();

      // Tiny 3x2 frame with step 2: full order, ignored write, read past end, restart
      write_csr(CSR_IMG_WIDTH, 32'd3);
      write_csr(CSR_IMG_HEIGHT, 32'd2);
      write_csr(CSR_STEP_LOG2, 32'd1);
      queue_item(ACT_START, 8'h00);
      queue_item(ACT_WRITE, 8'h00);
      queue_item(ACT_WRITE, 8'hFF);
      queue_item(ACT_WRITE, 8'h55);
      queue_item(ACT_WRITE, 8'hAA);
      queue_item(ACT_WRITE, 8'h01);
      queue_item(ACT_WRITE, 8'h80);
      queue_item(ACT_WRITE, 8'h7F);
      repeat (6) queue_item(ACT_READ, 8'h00);
      queue_item(ACT_READ, 8'hFF);
      queue_item(ACT_UNUSED, 8'h00);
      queue_item(ACT_START, 8'hFF);
      queue_item(ACT_READ, 8'h00);

      // Random phases over a spread of frame shapes and steps
      run_phase(32'd1, 32'd1, 32'd0, IDLE_NONE, 20, 1'b0);
      run_phase(32'd5, 32'd7, 32'd6, IDLE_SEND, 40, 1'b1);
      run_phase(32'd0, 32'd9, 32'd2, IDLE_RECV, 20, 1'b0);
      run_phase(32'hFFFF_FE06, 32'd4, 32'h0000_000B, IDLE_BOTH, 20, 1'b0);
      run_phase(32'd3, 32'd0, 32'd1, IDLE_SEND, 20, 1'b0);
      run_phase(32'd300, 32'd1, 32'd3, IDLE_BOTH, 1, 1'b0);
      run_phase(32'd1, 32'd511, 32'd7, IDLE_NONE, 1, 1'b0);
      run_phase(32'($urandom_range(1, 6)), 32'($urandom_range(1, 6)),
                32'($urandom_range(0, 7)), IDLE_NONE, 20, 1'b0);
      run_phase(32'($urandom_range(1, 6)), 32'($urandom_range(1, 6)),
                32'($urandom_range(0, 7)), IDLE_SEND, 20, 1'b0);
      run_phase(32'($urandom_range(1, 6)), 32'($urandom_range(1, 6)),
                32'($urandom_range(0, 7)), IDLE_RECV, 20, 1'b1);
      run_phase(32'($urandom_range(1, 6)), 32'($urandom_range(1, 6)),
                32'($urandom_range(0, 7)), IDLE_BOTH, 20, 1'b0);

      drain_all();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ppir_pkg.sv
rtl/core/ppir_req_if.sv
rtl/core/ppir_rsp_if.sv
rtl/core/ppir_ram.sv
rtl/core/ppir_ctrl.sv
rtl/core/ppir_datapath.sv
rtl/core/progressive_pixel_interleave_reorder_unit.sv
tb/sv/tb.sv
